### src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// shared constants for the rotation matrix to quaternion datapath
// ----------------------------------------------------------------------------
package rmq_pkg;

  // quaternion components carried side by side through the cells (w, x, y, z)
  localparam int NUM_COMP = 4;
  // matrix elements per input transfer
  localparam int NUM_ELEM = 9;

endpackage

### src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// branch select, raw component sums and pivot, registered
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
  parameter int W = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [NUM_ELEM*W-1:0]        in_mat,
  output logic                         out_vld,
  output logic [2*W-1:0]               out_rad,
  output logic [NUM_COMP*(W+2)-1:0]    out_comp,
  output logic                         out_inv
);

  localparam int CW = W + 2;
  localparam int F  = W - 2;
  localparam logic signed [CW-1:0] ONE = CW'(1) << F;

  logic signed [CW-1:0] e [NUM_ELEM];
  logic signed [CW-1:0] tr;
  logic signed [CW-1:0] c0, c1, c2, c3, piv;

  logic                         vld_r;
  logic [2*W-1:0]               rad_r, rad_nxt;
  logic [NUM_COMP*CW-1:0]       comp_r, comp_nxt;
  logic                         inv_r, inv_nxt;

  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      e[i] = {{2{in_mat[i*W+W-1]}}, in_mat[i*W +: W]};
    end
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      c0 = tr + ONE;
      c1 = e[5] - e[7];
      c2 = e[6] - e[2];
      c3 = e[1] - e[3];
      piv = c0;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      c0 = e[5] - e[7];
      c1 = ONE + e[0] - e[4] - e[8];
      c2 = e[3] + e[1];
      c3 = e[6] + e[2];
      piv = c1;
    end else if (e[4] > e[8]) begin
      c0 = e[6] - e[2];
      c1 = e[3] + e[1];
      c2 = ONE + e[4] - e[0] - e[8];
      c3 = e[7] + e[5];
      piv = c2;
    end else begin
      c0 = e[1] - e[3];
      c1 = e[6] + e[2];
      c2 = e[7] + e[5];
      c3 = ONE + e[8] - e[0] - e[4];
      piv = c3;
    end
    comp_nxt = {c3, c2, c1, c0};
    inv_nxt  = (piv <= 0);
    // radicand is pivot scaled by 2^F, top bit always zero
    rad_nxt  = {1'b0, piv[W:0], {F{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= rad_nxt;
      comp_r <= comp_nxt;
      inv_r  <= inv_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_comp = comp_r;
  assign out_inv  = inv_r;

endmodule

### src/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// one root bit of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int W = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [2*W-1:0]               in_rad,
  input  logic [W+1:0]                 in_rem,
  input  logic [W-1:0]                 in_root,
  input  logic [NUM_COMP*(W+2)-1:0]    in_comp,
  input  logic                         in_inv,
  output logic                         out_vld,
  output logic [2*W-1:0]               out_rad,
  output logic [W+1:0]                 out_rem,
  output logic [W-1:0]                 out_root,
  output logic [NUM_COMP*(W+2)-1:0]    out_comp,
  output logic                         out_inv
);

  logic [W+1:0] rem_sh, trial;
  logic         ge;

  logic                         vld_r;
  logic [2*W-1:0]               rad_r, rad_nxt;
  logic [W+1:0]                 rem_r, rem_nxt;
  logic [W-1:0]                 root_r, root_nxt;
  logic [NUM_COMP*(W+2)-1:0]    comp_r;
  logic                         inv_r;

  always_comb begin
    // bring down the next two radicand bits
    rem_sh   = {in_rem[W-1:0], in_rad[2*W-1 -: 2]};
    trial    = {in_root, 2'b01};
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {in_root[W-2:0], ge};
    rad_nxt  = {in_rad[2*W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      comp_r <= in_comp;
      inv_r  <= in_inv;
    end
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_comp = comp_r;
  assign out_inv  = inv_r;

endmodule

### src/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// rmq_div_cell
// one quotient bit of restoring division, four components in parallel
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; #(
  parameter int W = 16,
  parameter int K = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [W:0]                   in_den,
  input  logic [NUM_COMP*2*W-1:0]      in_rem,
  input  logic [NUM_COMP*W-1:0]        in_quo,
  input  logic [NUM_COMP-1:0]          in_neg,
  input  logic [NUM_COMP-1:0]          in_ovf,
  input  logic                         in_inv,
  output logic                         out_vld,
  output logic [W:0]                   out_den,
  output logic [NUM_COMP*2*W-1:0]      out_rem,
  output logic [NUM_COMP*W-1:0]        out_quo,
  output logic [NUM_COMP-1:0]          out_neg,
  output logic [NUM_COMP-1:0]          out_ovf,
  output logic                         out_inv
);

  logic [2*W:0] dsh;
  logic [2*W:0] rem_x;
  logic         ge;

  logic                         vld_r;
  logic [W:0]                   den_r;
  logic [NUM_COMP*2*W-1:0]      rem_r, rem_nxt;
  logic [NUM_COMP*W-1:0]        quo_r, quo_nxt;
  logic [NUM_COMP-1:0]          neg_r, ovf_r;
  logic                         inv_r;

  always_comb begin
    dsh = (2*W+1)'(in_den) << K;
    rem_nxt = in_rem;
    quo_nxt = in_quo;
    rem_x   = '0;
    ge      = 1'b0;
    for (int l = 0; l < NUM_COMP; l++) begin
      rem_x = {1'b0, in_rem[l*2*W +: 2*W]};
      ge    = (rem_x >= dsh);
      if (ge) begin
        rem_nxt[l*2*W +: 2*W] = (2*W)'(rem_x - dsh);
      end
      quo_nxt[l*W + K] = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r <= in_den;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      neg_r <= in_neg;
      ovf_r <= in_ovf;
      inv_r <= in_inv;
    end
  end

  assign out_vld = vld_r;
  assign out_den = den_r;
  assign out_rem = rem_r;
  assign out_quo = quo_r;
  assign out_neg = neg_r;
  assign out_ovf = ovf_r;
  assign out_inv = inv_r;

endmodule

### src/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix to unit quaternion, branch on trace / largest diagonal
// ----------------------------------------------------------------------------
// throughput: one matrix per cycle while not stalled; square root and division
//   are chains of one-bit cells, DATA_WIDTH cells each, all advancing together
// stalls only when the output register is full and not taken
// reset clears all valid bits; no clearing pass, the block is ready at once
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  input  logic [((NUM_ELEM*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // qw, qx, qy, qz from the lowest bit up
  output logic [((NUM_COMP*DATA_WIDTH+7)/8)*8-1:0] out_tdata,
  // invalid
  output logic out_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int CW  = W + 2;
  localparam int F   = W - 2;
  localparam int OBW = ((NUM_COMP*W+7)/8)*8;

  logic adv;

  // square root chain
  logic                         sq_vld  [W+1];
  logic [2*W-1:0]               sq_rad  [W+1];
  logic [W+1:0]                 sq_rem  [W+1];
  logic [W-1:0]                 sq_root [W+1];
  logic [NUM_COMP*CW-1:0]       sq_comp [W+1];
  logic                         sq_inv  [W+1];

  // division chain
  logic                         dv_vld [W+1];
  logic [W:0]                   dv_den [W+1];
  logic [NUM_COMP*2*W-1:0]      dv_rem [W+1];
  logic [NUM_COMP*W-1:0]        dv_quo [W+1];
  logic [NUM_COMP-1:0]          dv_neg [W+1];
  logic [NUM_COMP-1:0]          dv_ovf [W+1];
  logic                         dv_inv [W+1];

  // prep stage between the chains
  logic                         pp_vld_r;
  logic [W:0]                   pp_den_r, pp_den_nxt;
  logic [NUM_COMP*2*W-1:0]      pp_rem_r, pp_rem_nxt;
  logic [NUM_COMP-1:0]          pp_neg_r, pp_neg_nxt;
  logic [NUM_COMP-1:0]          pp_ovf_r, pp_ovf_nxt;
  logic                         pp_inv_r;
  logic [W-1:0]                 s_val;
  logic signed [CW-1:0]         c_val;
  logic [CW-1:0]                mag;
  logic [2*W-1:0]               dvd;

  // output register
  logic                         out_vld_r;
  logic [NUM_COMP*W-1:0]        out_data_r, out_data_nxt;
  logic                         out_user_r;
  logic [W-1:0]                 r_val;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  rmq_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_tvalid),
    .in_mat   (in_tdata[NUM_ELEM*W-1:0]),
    .out_vld  (sq_vld[0]),
    .out_rad  (sq_rad[0]),
    .out_comp (sq_comp[0]),
    .out_inv  (sq_inv[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < W; j++) begin : g_sqrt
    rmq_sqrt_cell #(.W(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (sq_vld[j]),
      .in_rad   (sq_rad[j]),
      .in_rem   (sq_rem[j]),
      .in_root  (sq_root[j]),
      .in_comp  (sq_comp[j]),
      .in_inv   (sq_inv[j]),
      .out_vld  (sq_vld[j+1]),
      .out_rad  (sq_rad[j+1]),
      .out_rem  (sq_rem[j+1]),
      .out_root (sq_root[j+1]),
      .out_comp (sq_comp[j+1]),
      .out_inv  (sq_inv[j+1])
    );
  end

  // dividend c*2^F + s over divisor 2s gives the rounded quotient
  always_comb begin
    s_val      = (sq_root[W] == '0) ? W'(1) : sq_root[W];
    pp_den_nxt = {s_val, 1'b0};
    pp_rem_nxt = '0;
    pp_neg_nxt = '0;
    pp_ovf_nxt = '0;
    c_val      = '0;
    mag        = '0;
    dvd        = '0;
    for (int l = 0; l < NUM_COMP; l++) begin
      c_val = sq_comp[W][l*CW +: CW];
      mag   = c_val[CW-1] ? CW'(-c_val) : CW'(c_val);
      dvd   = (2*W)'({mag[W:0], {F{1'b0}}}) + (2*W)'(s_val);
      pp_neg_nxt[l] = c_val[CW-1];
      // quotient at or above 2^W always saturates
      pp_ovf_nxt[l] = ({1'b0, dvd} >= {pp_den_nxt, {W{1'b0}}});
      pp_rem_nxt[l*2*W +: 2*W] = dvd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else if (adv) begin
      pp_vld_r <= sq_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_den_r <= pp_den_nxt;
      pp_rem_r <= pp_rem_nxt;
      pp_neg_r <= pp_neg_nxt;
      pp_ovf_r <= pp_ovf_nxt;
      pp_inv_r <= sq_inv[W];
    end
  end

  assign dv_vld[0] = pp_vld_r;
  assign dv_den[0] = pp_den_r;
  assign dv_rem[0] = pp_rem_r;
  assign dv_quo[0] = '0;
  assign dv_neg[0] = pp_neg_r;
  assign dv_ovf[0] = pp_ovf_r;
  assign dv_inv[0] = pp_inv_r;

  for (genvar j = 0; j < W; j++) begin : g_div
    rmq_div_cell #(.W(W), .K(W-1-j)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (dv_vld[j]),
      .in_den  (dv_den[j]),
      .in_rem  (dv_rem[j]),
      .in_quo  (dv_quo[j]),
      .in_neg  (dv_neg[j]),
      .in_ovf  (dv_ovf[j]),
      .in_inv  (dv_inv[j]),
      .out_vld (dv_vld[j+1]),
      .out_den (dv_den[j+1]),
      .out_rem (dv_rem[j+1]),
      .out_quo (dv_quo[j+1]),
      .out_neg (dv_neg[j+1]),
      .out_ovf (dv_ovf[j+1]),
      .out_inv (dv_inv[j+1])
    );
  end

  // sign, saturation and invalid zeroing
  always_comb begin
    out_data_nxt = '0;
    r_val        = '0;
    for (int l = 0; l < NUM_COMP; l++) begin
      r_val = dv_quo[W][l*W +: W];
      if (dv_inv[W]) begin
        out_data_nxt[l*W +: W] = '0;
      end else if (dv_neg[W][l]) begin
        if (dv_ovf[W][l] || r_val > {1'b1, {(W-1){1'b0}}}) begin
          out_data_nxt[l*W +: W] = {1'b1, {(W-1){1'b0}}};
        end else begin
          out_data_nxt[l*W +: W] = W'(-r_val);
        end
      end else begin
        if (dv_ovf[W][l] || r_val[W-1]) begin
          out_data_nxt[l*W +: W] = {1'b0, {(W-1){1'b1}}};
        end else begin
          out_data_nxt[l*W +: W] = r_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dv_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_user_r <= dv_inv[W];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OBW'(out_data_r);
  assign out_tuser  = out_user_r;

endmodule

### src/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// port-level checks on the quaternion converter, bound to the top level
// ----------------------------------------------------------------------------
module rmq_checker import rmq_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((NUM_COMP*DATA_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // input side opens exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output register state");

  // invalid results carry zeros
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("invalid result with nonzero components");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
